/* sv/bse_pkg.sv */
// Shared types, character constants and the hex digit helper for the backslash escape encoder.
package bse_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] PRINT_LOW      = 8'h20;
   localparam logic [7:0] PRINT_HIGH     = 8'h7E;

   localparam logic [7:0] CTRL_NUL = 8'h00;
   localparam logic [7:0] CTRL_BEL = 8'h07;
   localparam logic [7:0] CTRL_BS  = 8'h08;
   localparam logic [7:0] CTRL_TAB = 8'h09;
   localparam logic [7:0] CTRL_LF  = 8'h0A;
   localparam logic [7:0] CTRL_VT  = 8'h0B;
   localparam logic [7:0] CTRL_FF  = 8'h0C;
   localparam logic [7:0] CTRL_CR  = 8'h0D;

   // Index of the final word in a run, which holds one, two or four words.
   localparam logic [1:0] LAST_IDX_ONE  = 2'd0;
   localparam logic [1:0] LAST_IDX_TWO  = 2'd1;
   localparam logic [1:0] LAST_IDX_FOUR = 2'd3;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
   } run_type;

   // Upper-case hex digit for one nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ext;
      ext = {4'd0, nib};
      if (nib < 4'd10) begin
         hex_char = CHAR_ZERO + ext;
      end else begin
         hex_char = CHAR_UPPER_A + ext - 8'd10;
      end
   endfunction

endpackage

/* sv/bse_encode.sv */
// Combinational encoder that turns one raw byte into its escaped run of words.
module bse_encode
   import bse_pkg::*;
(
   input  logic [7:0] raw_byte,
   output run_type    run
);

   logic [7:0] sym;

   always_comb begin
      case (raw_byte)
         CTRL_NUL:       sym = 8'h30;  // '0'
         CTRL_BEL:       sym = 8'h61;  // 'a'
         CTRL_BS:        sym = 8'h62;  // 'b'
         CTRL_TAB:       sym = 8'h74;  // 't'
         CTRL_LF:        sym = 8'h6E;  // 'n'
         CTRL_VT:        sym = 8'h76;  // 'v'
         CTRL_FF:        sym = 8'h66;  // 'f'
         CTRL_CR:        sym = 8'h72;  // 'r'
         CHAR_BACKSLASH: sym = CHAR_BACKSLASH;
         default:        sym = 8'h00;
      endcase
   end

   always_comb begin
      run.bytes    = '0;
      run.last_idx = LAST_IDX_FOUR;
      if ((raw_byte inside {[PRINT_LOW:PRINT_HIGH]}) && (raw_byte != CHAR_BACKSLASH)) begin
         run.bytes[0] = raw_byte;
         run.last_idx = LAST_IDX_ONE;
      end else if (sym != 8'h00) begin
         run.bytes[0] = CHAR_BACKSLASH;
         run.bytes[1] = sym;
         run.last_idx = LAST_IDX_TWO;
      end else begin
         run.bytes[0] = CHAR_BACKSLASH;
         run.bytes[1] = CHAR_X;
         run.bytes[2] = hex_char(raw_byte[7:4]);
         run.bytes[3] = hex_char(raw_byte[3:0]);
      end
   end

endmodule

/* sv/bse_run.sv */
// Result register that holds one escaped run and sends it out one word per cycle while not stalled.
module bse_run
   import bse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  run_type    run_load,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   run_type    run_ff, run_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       take;
   logic       at_last;

   assign at_last = (idx_ff == run_ff.last_idx);
   assign take    = valid_ff && !rsp_stall;
   // Free when empty, or when the last word of the run leaves this cycle.
   assign free    = !valid_ff || (take && at_last);

   always_comb begin
      run_in   = run_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         run_in   = run_load;
         idx_in   = 2'd0;
         valid_in = 1'b1;
      end else if (take && at_last) begin
         valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      run_ff <= run_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = run_ff.bytes[idx_ff];
   assign rsp_last_of_run = at_last;

endmodule

/* sv/backslash_escape_encoder.sv */
// Top level of the backslash escape encoder: input register, encoder and run output register.
// A word accepted into the input register is encoded and loaded into the run register when that
// register is free, and its first result word then comes out of the run register.
// Throughput: one input word per cycle for bytes that pass through while rsp_stall is low; an
// escaped byte gives two or four result words, as the run register sends one result word per cycle.
// Reset (synchronous, active high) empties the input and run registers; there is no other state.
module backslash_escape_encoder
   import bse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   // The input register holds one raw word until the run register can take its run.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       req_take;
   logic       load;
   logic       run_free;
   run_type    run_enc;

   // A waiting word moves into the run register as soon as the current run is done,
   // which includes the cycle in which its last word is taken.
   assign load      = in_valid_ff && run_free;
   assign req_stall = in_valid_ff && !load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   // The escape logic sits between the input register and the run register.
   bse_encode u_encode (
      .raw_byte (in_byte_ff),
      .run      (run_enc)
   );

   bse_run u_run (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .run_load        (run_enc),
      .free            (run_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

/* tb/sv/escape_run_board_pkg.sv */
// Scoreboard that predicts and checks the escaped byte runs of the backslash escape encoder.
`timescale 1ns / 100ps

package escape_run_board_pkg;

   import bse_pkg::*;

   class escape_run_board;

      logic [7:0] want_bytes[$];
      logic       want_lasts[$];
      int         failures;

      function new();
         failures = 0;
      endfunction

      function void push_word(logic [7:0] value, logic last);
         want_bytes.push_back(value);
         want_lasts.push_back(last);
      endfunction

      function logic [7:0] hex_digit_of(logic [3:0] nib);
         if (nib < 4'd10) begin
            return 8'h30 + {4'd0, nib};
         end
         return 8'h41 + {4'd0, nib} - 8'd10;
      endfunction

      // Expands one accepted raw byte into the run of words it should produce.
      function void note_word(logic [7:0] raw);
         logic [7:0] sym;
         sym = 8'h00;
         if (raw >= PRINT_LOW && raw <= PRINT_HIGH && raw != CHAR_BACKSLASH) begin
            push_word(raw, 1'b1);
            return;
         end
         case (raw)
            CTRL_NUL:       sym = "0";
            CTRL_BEL:       sym = "a";
            CTRL_BS:        sym = "b";
            CTRL_TAB:       sym = "t";
            CTRL_LF:        sym = "n";
            CTRL_VT:        sym = "v";
            CTRL_FF:        sym = "f";
            CTRL_CR:        sym = "r";
            CHAR_BACKSLASH: sym = CHAR_BACKSLASH;
            default:        sym = 8'h00;
         endcase
         push_word(CHAR_BACKSLASH, 1'b0);
         if (sym != 8'h00) begin
            push_word(sym, 1'b1);
         end else begin
            push_word(CHAR_X, 1'b0);
            push_word(hex_digit_of(raw[7:4]), 1'b0);
            push_word(hex_digit_of(raw[3:0]), 1'b1);
         end
      endfunction

      function void report(string what, logic [7:0] want, logic [7:0] got);
         failures++;
         $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
      endfunction

      // Compares one accepted result word with the oldest word still expected.
      function void check_word(logic [7:0] got_byte, logic got_last);
         logic [7:0] want_byte;
         logic       want_last;
         if (want_bytes.size() == 0) begin
            report("unexpected word, byte", 8'h00, got_byte);
            return;
         end
         want_byte = want_bytes.pop_front();
         want_last = want_lasts.pop_front();
         if (got_byte !== want_byte) begin
            report("out_byte", want_byte, got_byte);
         end
         if (got_last !== want_last) begin
            report("last_of_run", {7'd0, want_last}, {7'd0, got_last});
         end
      endfunction

      function int pending();
         return want_bytes.size();
      endfunction

   endclass

endpackage

/* tb/sv/backslash_escape_encoder_test.sv */
// Top-level testbench for the backslash escape encoder: clock, reset, stimulus and checking.
`timescale 1ns / 100ps

module backslash_escape_encoder_test;

   import bse_pkg::*;
   import escape_run_board_pkg::*;

   // The run is ended here if it has not finished by then. The slowest correct run is
   // roughly 210 words, each giving four result words that may each wait out a receiver
   // stall, plus sender gaps and the long receiver hold; this is several times that.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 80;
   localparam int HOLD_WORDS    = 40;
   localparam int RANDOM_WORDS  = 146;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;

   // Handshake between the stimulus and the receiver for the long hold-off.
   logic hold_request = 1'b0;
   logic hold_active  = 1'b0;

   int cycles = 0;

   escape_run_board board = new();

   backslash_escape_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #1 clock = ~clock;

   // The watchdog counts cycles and gives up once the limit is passed.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Most gaps are absent or short; now and then a long one falls in.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Random bytes lean toward plain text, with a fair share of short escapes and of
   // bytes that need the hex form, so that all three run lengths are well exercised.
   function automatic logic [7:0] pick_byte();
      logic [7:0] short_set[9];
      int         roll;
      short_set = '{CTRL_NUL, CTRL_BEL, CTRL_BS, CTRL_TAB, CTRL_LF,
                    CTRL_VT, CTRL_FF, CTRL_CR, CHAR_BACKSLASH};
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         return 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
      end else if (roll < 60) begin
         return short_set[$urandom_range(0, 8)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Offers one word and holds it until the block takes it. The prediction is made at
   // the edge where the word is accepted. A gap then lowers valid for the length of the gap;
   // without a gap valid stays high and the next call simply changes the payload.
   task automatic send_word(input logic [7:0] raw, input int gap);
      req_valid   <= 1'b1;
      req_in_byte <= raw;
      do begin
         @(posedge clock);
      end while (req_stall);
      board.note_word(raw);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Every accepted result word is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_word(rsp_out_byte, rsp_last_of_run);
      end
   end

   // The receiver alternates between stretches where it stalls and stretches where it
   // takes every word. When the stimulus asks for it, it holds off for a long stretch,
   // which it counts itself, so that the block backs up and stalls its input.
   initial begin : receiver
      int run;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall   <= 1'b1;
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            hold_active  = 1'b0;
         end
         run = pick_gap();
         if (run > 0) begin
            rsp_stall <= 1'b1;
            repeat (run) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(30, 60)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [7:0] directed[$];
      directed = '{CTRL_NUL, CTRL_BEL, CTRL_BS, CTRL_TAB, CTRL_LF, CTRL_VT, CTRL_FF,
                   CTRL_CR, CHAR_BACKSLASH, PRINT_LOW, PRINT_HIGH, 8'h1F, 8'h7F,
                   8'h80, 8'hFF, 8'h01, 8'h06, 8'h0E, 8'h5B, 8'h5D, 8'h41, 8'hE9,
                   8'hA5, 8'h5A};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words: both ends of the printable range and the bytes just outside it,
      // every short escape including the backslash itself, and hex-form bytes whose
      // digits land on both the numeric and the letter side, including the byte with all bits at 1.
      foreach (directed[i]) begin
         send_word(directed[i], pick_gap());
      end

      // First random half with idling on both sides.
      for (int i = 0; i < RANDOM_WORDS / 2; i++) begin
         send_word(pick_byte(), pick_gap());
      end

      // The sender stops and waits until every expected word has come out.
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);

      // The receiver holds off for a long stretch while words keep coming back to back,
      // so the block fills up and has to stall its input.
      hold_request = 1'b1;
      while (!hold_active) @(posedge clock);
      for (int i = 0; i < HOLD_WORDS; i++) begin
         send_word(pick_byte(), 0);
      end

      // Second random half.
      for (int i = 0; i < RANDOM_WORDS / 2; i++) begin
         send_word(pick_byte(), pick_gap());
      end
      req_valid <= 1'b0;

      // Drain, then allow a few more cycles so a stray extra word would still be seen.
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (board.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
